/* src/lgs_pkg.sv */
// Shared types and constants for the toroidal life generation block.
package lgs_pkg;

    // Width of a cell coordinate field on the input stream.
    localparam int COORD_W = 6;

    // Width of the operation kind field.
    localparam int KIND_W = 2;

    // Neighbor count that brings a dead cell to life, and the extra count a live cell survives.
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // Operation kinds carried in tuser.
    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE   = 2'd0,
        KIND_READ    = 2'd1,
        KIND_ADVANCE = 2'd2
    } kind_e_t;

    // Sequencer states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // Control from the sequencer to the row ring and its datapath.
    typedef struct packed {
        logic shift;    // ring rotates by one row this cycle
        logic first;    // head holds the first row of the pass
        logic last;     // head holds the last row of the pass
        logic row_hit;  // head holds the addressed row
        logic emit;     // pass completes and the result is loaded
    } lgs_ctrl_t;

endpackage

/* src/lgs_row_cell.sv */
// One row cell of the grid ring: holds a row and takes its neighbor's row on a shift.
module lgs_row_cell #(
    parameter int WIDTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift,
    input  logic [WIDTH-1:0] shift_in,
    output logic [WIDTH-1:0] row_q
);

    logic [WIDTH-1:0] row_reg;
    logic [WIDTH-1:0] row_next;

    // Take the neighbor's row when the ring rotates, otherwise hold.
    always_comb begin
        row_next = shift ? shift_in : row_reg;
    end

    // All cells are dead after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
        end else begin
            row_reg <= row_next;
        end
    end

    assign row_q = row_reg;

endmodule

/* src/lgs_row_eval.sv */
// Computes one new generation row from the rows above, at and below it.
module lgs_row_eval #(
    parameter int WIDTH = 64
) (
    input  logic [WIDTH-1:0] north,
    input  logic [WIDTH-1:0] center,
    input  logic [WIDTH-1:0] south,
    output logic [WIDTH-1:0] new_row
);

    import lgs_pkg::*;

    // Each column counts its eight neighbors, wrapping at the left and right edges.
    always_comb begin
        int         cw;
        int         ce;
        logic [3:0] n;
        new_row = '0;
        for (int c = 0; c < WIDTH; c++) begin
            cw = (c == 0) ? WIDTH - 1 : c - 1;
            ce = (c == WIDTH - 1) ? 0 : c + 1;
            n = 4'(north[cw]) + 4'(north[c]) + 4'(north[ce])
              + 4'(center[cw]) + 4'(center[ce])
              + 4'(south[cw]) + 4'(south[c]) + 4'(south[ce]);
            new_row[c] = (n == BIRTH_COUNT) || (center[c] && (n == SURVIVE_COUNT));
        end
    end

endmodule

/* src/lgs_ctrl.sv */
// Sequencer that walks the row ring once per transaction.
module lgs_ctrl #(
    parameter int ROWS = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [lgs_pkg::COORD_W-1:0] row_sel,
    input  logic                       out_free,
    output logic                       idle,
    output lgs_pkg::lgs_ctrl_t         ctrl
);

    import lgs_pkg::*;

    localparam int ROW_W = $clog2(ROWS);

    state_t           state_reg;
    state_t           state_next;
    logic [ROW_W-1:0] step_reg;
    logic [ROW_W-1:0] step_next;
    logic             last;
    logic             shift;

    assign last  = (step_reg == ROW_W'(ROWS - 1));
    assign shift = (state_reg == ST_RUN) && (!last || out_free);

    // Next state and step count.
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN: begin
                if (shift) begin
                    step_next = step_reg + 1'b1;
                    if (last) begin
                        state_next = ST_IDLE;
                        step_next  = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Control bundle for the datapath.
    assign idle         = (state_reg == ST_IDLE);
    assign ctrl.shift   = shift;
    assign ctrl.first   = (step_reg == '0);
    assign ctrl.last    = last;
    assign ctrl.row_hit = (COORD_W'(step_reg) == row_sel);
    assign ctrl.emit    = shift && last;

endmodule

/* src/life_generation_step.sv */
// Top level of the toroidal life grid: a ring of row cells with read, write and advance.
// Each item rotates the row ring once, one row per cycle past the head, where the row evaluator
// sits, but for a hold on the last row: a result waiting on m_tready holds the ring there
// until it is taken. A new transaction is accepted only once the ring is idle again.
// Synchronous active-low reset clears the whole grid to dead.
module life_generation_step #(
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [5:0] col, [11:6] row, [12] alive_in
    input  logic [1:0]  s_tuser,  // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // [0] alive_out
    output logic [1:0]  m_tuser   // [1:0] kind_done
);

    import lgs_pkg::*;

    localparam int COL_IW = $clog2(GRID_COLS);

    lgs_ctrl_t               ctrl;
    logic                    idle;
    logic                    accept;
    logic                    out_free;

    logic [KIND_W-1:0]       kind_reg;
    logic [COORD_W-1:0]      col_reg;
    logic [COORD_W-1:0]      row_reg;
    logic                    alive_in_reg;
    logic                    is_adv;
    logic                    is_read;
    logic                    on_grid;
    logic [COL_IW-1:0]       col_idx;

    logic [GRID_COLS-1:0]    rows_q [GRID_ROWS];
    logic [GRID_COLS-1:0]    head;
    logic [GRID_COLS-1:0]    tail_in;
    logic [GRID_COLS-1:0]    north;
    logic [GRID_COLS-1:0]    south;
    logic [GRID_COLS-1:0]    eval_row;
    logic [GRID_COLS-1:0]    bit_mask;
    logic [GRID_COLS-1:0]    wr_row;
    logic [GRID_COLS-1:0]    win_reg;
    logic [GRID_COLS-1:0]    save0_reg;

    logic                    res_alive_reg;
    logic                    res_alive_next;
    logic                    m_tvalid_reg;
    logic                    alive_out_reg;
    logic [KIND_W-1:0]       kind_done_reg;

    // Input handshake.
    assign s_tready = idle;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Latch the accepted transaction.
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg     <= s_tuser;
            col_reg      <= s_tdata[5:0];
            row_reg      <= s_tdata[11:6];
            alive_in_reg <= s_tdata[12];
        end
    end

    // Decode the operation; the unused kind code behaves as a read.
    assign is_adv  = (kind_reg == KIND_ADVANCE);
    assign is_read = !is_adv && kind_reg[0];
    assign on_grid = (7'(col_reg) < 7'(GRID_COLS));
    assign col_idx = col_reg[COL_IW-1:0];

    lgs_ctrl #(
        .ROWS (GRID_ROWS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .row_sel  (row_reg),
        .out_free (out_free),
        .idle     (idle),
        .ctrl     (ctrl)
    );

    // Ring of row cells; the head is cell zero and the tail takes the new row.
    for (genvar i = 0; i < GRID_ROWS; i++) begin : g_ring
        logic [GRID_COLS-1:0] cell_in;
        if (i == GRID_ROWS - 1) begin : g_tail
            assign cell_in = tail_in;
        end else begin : g_body
            assign cell_in = rows_q[i+1];
        end
        lgs_row_cell #(
            .WIDTH (GRID_COLS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift    (ctrl.shift),
            .shift_in (cell_in),
            .row_q    (rows_q[i])
        );
    end

    assign head = rows_q[0];

    // Window around the head row; the old first row is kept for the wrap at the end.
    assign north = ctrl.first ? rows_q[GRID_ROWS-1] : win_reg;
    assign south = ctrl.last ? save0_reg : rows_q[1];

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            win_reg <= head;
        end
        if (ctrl.shift && ctrl.first) begin
            save0_reg <= head;
        end
    end

    lgs_row_eval #(
        .WIDTH (GRID_COLS)
    ) u_eval (
        .north   (north),
        .center  (head),
        .south   (south),
        .new_row (eval_row)
    );

    // Row written back at the tail: new generation, edited row, or the head unchanged.
    assign bit_mask = GRID_COLS'(1) << col_idx;
    assign wr_row   = alive_in_reg ? (head | bit_mask) : (head & ~bit_mask);

    always_comb begin
        if (is_adv) begin
            tail_in = eval_row;
        end else if (!is_read && ctrl.row_hit && on_grid) begin
            tail_in = wr_row;
        end else begin
            tail_in = head;
        end
    end

    // Result bit collected while the addressed row passes the head.
    always_comb begin
        res_alive_next = res_alive_reg;
        if (accept) begin
            res_alive_next = 1'b0;
        end else if (ctrl.shift && ctrl.row_hit && !is_adv && on_grid) begin
            res_alive_next = is_read ? head[col_idx] : alive_in_reg;
        end
    end

    always_ff @(posedge aclk) begin
        res_alive_reg <= res_alive_next;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            alive_out_reg <= res_alive_next;
            if (is_adv) begin
                kind_done_reg <= KIND_ADVANCE;
            end else if (is_read) begin
                kind_done_reg <= KIND_READ;
            end else begin
                kind_done_reg <= KIND_WRITE;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, alive_out_reg};
    assign m_tuser  = kind_done_reg;

`ifndef SYNTH
    // A transaction keeps the block busy for the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn) accept |=> !s_tready)
        else $error("input accepted again right after an accept");

    // Completing a pass always presents a result.
    assert property (@(posedge aclk) disable iff (!aresetn) ctrl.emit |=> m_tvalid)
        else $error("result not presented after pass completion");

    // An advance answers with a dead cell bit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == 2'(KIND_ADVANCE))) |-> !m_tdata[0])
        else $error("advance result carries a live bit");

    // The ring never rotates while the block is idle.
    assert property (@(posedge aclk) disable iff (!aresetn) s_tready |-> !ctrl.shift)
        else $error("row ring rotates while idle");
`endif

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the toroidal life grid: cell writes, reads and generation steps.
`timescale 1ns / 1ps

module testbench;
    import lgs_pkg::*;

    localparam int ROWS = 64;
    localparam int COLS = 64;

    // Kind 3 is not an operation of its own; the block treats it as a read.
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    // Receiver hold-off that backs the block up into its input.
    localparam int HOLD_AT_RESULT = 300;
    localparam int HOLD_CYCLES    = 600;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               alive;
    } cell_op_t;

    typedef struct packed {
        logic              alive;
        logic [KIND_W-1:0] kind;
    } cell_answer_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;

    // Stimulus and prediction state.
    cell_op_t     op_queue[$];
    cell_answer_t answer_queue[$];
    logic [COLS-1:0] life_grid [ROWS];
    cell_op_t     cur_op;
    cell_op_t     next_op;
    int           total_ops   = 0;
    int           accepted_n  = 0;
    int           answered_n  = 0;
    int           error_n     = 0;
    int           send_gap    = 0;
    int           recv_wait   = 1;
    int           hold_left   = 0;
    logic         hold_done   = 1'b0;
    logic         rdy_nxt;
    int           draw_n;
    cell_answer_t exp_answer;

    always #5 aclk = ~aclk;

    life_generation_step i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Every fourth block of 128 transactions runs without any idling on either side.
    function automatic int draw_wait();
        if ((accepted_n / 128) % 4 == 3) return 0;
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 17);
    endfunction

    // Builds the next generation from the current one under B3/S23 with wrapped edges.
    task automatic step_generation();
        logic [COLS-1:0] fresh [ROWS];
        int rn, rs, cw, ce, nb;
        for (int r = 0; r < ROWS; r++) begin
            rn = (r + ROWS - 1) % ROWS;
            rs = (r + 1) % ROWS;
            for (int c = 0; c < COLS; c++) begin
                cw = (c + COLS - 1) % COLS;
                ce = (c + 1) % COLS;
                nb = life_grid[rn][cw] + life_grid[rn][c] + life_grid[rn][ce]
                   + life_grid[r][cw] + life_grid[r][ce]
                   + life_grid[rs][cw] + life_grid[rs][c] + life_grid[rs][ce];
                if (life_grid[r][c])
                    fresh[r][c] = (nb == 2 || nb == 3);
                else
                    fresh[r][c] = (nb == 3);
            end
        end
        for (int r = 0; r < ROWS; r++) life_grid[r] = fresh[r];
    endtask

    // Applies one accepted operation to the predicted grid and queues its answer.
    task automatic apply_cell_op(input cell_op_t op);
        cell_answer_t ans;
        ans.alive = 1'b0;
        if (op.kind == KIND_ADVANCE) begin
            step_generation();
            ans.kind = KIND_ADVANCE;
        end else if (op.kind[0]) begin
            ans.alive = life_grid[op.row][op.col];
            ans.kind  = KIND_READ;
        end else begin
            life_grid[op.row][op.col] = op.alive;
            ans.alive = op.alive;
            ans.kind  = KIND_WRITE;
        end
        answer_queue.push_back(ans);
    endtask

    task automatic push_op(input logic [1:0] kind, input logic [5:0] row, input logic [5:0] col,
                           input logic alive);
        cell_op_t op;
        op.kind  = kind;
        op.row   = row;
        op.col   = col;
        op.alive = alive;
        op_queue.push_back(op);
        total_ops++;
    endtask

    // A random pattern in a small window, stepped a few times and probed around the window.
    task automatic push_pattern();
        logic [5:0] r0, c0;
        int span, writes, steps;
        r0     = 6'($urandom_range(0, 63));
        c0     = 6'($urandom_range(0, 63));
        span   = $urandom_range(3, 8);
        writes = $urandom_range(4, 16);
        steps  = $urandom_range(1, 3);
        for (int i = 0; i < writes; i++)
            push_op(KIND_WRITE, r0 + 6'($urandom_range(0, span - 1)),
                    c0 + 6'($urandom_range(0, span - 1)), $urandom_range(0, 4) != 0);
        for (int s = 0; s < steps; s++) begin
            push_op(KIND_ADVANCE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                    1'($urandom_range(0, 1)));
            for (int k = $urandom_range(2, 6); k > 0; k--)
                push_op(($urandom_range(0, 7) == 0) ? KIND_SPARE : KIND_READ,
                        r0 + 6'($urandom_range(0, span + 1)) - 6'd1,
                        c0 + 6'($urandom_range(0, span + 1)) - 6'd1,
                        1'($urandom_range(0, 1)));
        end
    endtask

    // Stimulus: a directed opening, then random patterns mixed with noise.
    initial begin
        for (int r = 0; r < ROWS; r++) life_grid[r] = '0;

        // The grid starts empty.
        push_op(KIND_READ, 6'd5, 6'd5, 1'b1);
        // A horizontal blinker across the column wrap, and a cell in the far corner that touches it.
        push_op(KIND_WRITE, 6'd0, 6'd63, 1'b1);
        push_op(KIND_WRITE, 6'd0, 6'd0, 1'b1);
        push_op(KIND_WRITE, 6'd0, 6'd1, 1'b1);
        push_op(KIND_WRITE, 6'd63, 6'd63, 1'b1);
        push_op(KIND_READ, 6'd63, 6'd63, 1'b0);
        push_op(KIND_ADVANCE, 6'd0, 6'd0, 1'b0);
        // Row 63 stays dead above, a cell is born at row 1; the corner cell and two blinker cells survive.
        push_op(KIND_READ, 6'd63, 6'd0, 1'b0);
        push_op(KIND_READ, 6'd1, 6'd0, 1'b0);
        push_op(KIND_SPARE, 6'd0, 6'd0, 1'b0);
        push_op(KIND_READ, 6'd0, 6'd63, 1'b0);
        push_op(KIND_READ, 6'd63, 6'd63, 1'b0);
        // A still block in the middle survives with three neighbors each.
        push_op(KIND_WRITE, 6'd31, 6'd31, 1'b1);
        push_op(KIND_WRITE, 6'd31, 6'd32, 1'b1);
        push_op(KIND_WRITE, 6'd32, 6'd31, 1'b1);
        push_op(KIND_WRITE, 6'd32, 6'd32, 1'b1);
        // Clearing a cell, and writing dead over a dead cell.
        push_op(KIND_WRITE, 6'd0, 6'd0, 1'b0);
        push_op(KIND_WRITE, 6'd40, 6'd20, 1'b0);
        push_op(KIND_ADVANCE, 6'd63, 6'd63, 1'b1);
        push_op(KIND_SPARE, 6'd32, 6'd32, 1'b1);
        push_op(KIND_READ, 6'd0, 6'd0, 1'b0);
        push_op(KIND_READ, 6'd63, 6'd0, 1'b0);

        while (total_ops < 1075) begin
            if ($urandom_range(0, 9) == 0) begin
                for (int i = 0; i < 8; i++)
                    push_op(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                            6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            end else begin
                push_pattern();
            end
        end
    end

    // Reset once at the start of the run.
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Driver: offers queued operations, with a random gap after each transaction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_cell_op(cur_op);
                accepted_n <= accepted_n + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (op_queue.size() > 0) begin
                    next_op = op_queue.pop_front();
                    cur_op   <= next_op;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, next_op.alive, next_op.row, next_op.col};
                    s_tuser  <= next_op.kind;
                    send_gap <= draw_wait();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once a few hundred results have come.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && answered_n == HOLD_AT_RESULT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks each result transaction and stalls a random count of cycles per result.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait <= 1;
        end else begin
            rdy_nxt = m_tready;
            if (m_tvalid && m_tready) begin
                answered_n <= answered_n + 1;
                if (answer_queue.size() == 0) begin
                    $error("result with no operation pending: alive_out %0d kind_done %0d",
                           m_tdata[0], m_tuser);
                    error_n++;
                end else begin
                    exp_answer = answer_queue.pop_front();
                    if (m_tdata[0] !== exp_answer.alive) begin
                        $error("alive_out mismatch: expected %0d, actual %0d",
                               exp_answer.alive, m_tdata[0]);
                        error_n++;
                    end
                    if (m_tuser !== exp_answer.kind) begin
                        $error("kind_done mismatch: expected %0d, actual %0d",
                               exp_answer.kind, m_tuser);
                        error_n++;
                    end
                end
                draw_n = draw_wait();
                recv_wait <= draw_n;
                rdy_nxt = (draw_n == 0);
            end else if (m_tvalid && hold_left == 0) begin
                if (recv_wait <= 1) rdy_nxt = 1'b1;
                if (recv_wait > 0) recv_wait <= recv_wait - 1;
            end
            if (hold_left != 0) rdy_nxt = 1'b0;
            m_tready <= rdy_nxt;
        end
    end

    // End of test: all operations taken, all answers in, then a final drain before the verdict.
    initial begin
        @(posedge aresetn);
        while (total_ops == 0 || accepted_n != total_ops || answer_queue.size() != 0)
            @(posedge aclk);
        repeat (ROWS + 16) @(posedge aclk);
        if (error_n == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Watchdog for a hung block.
    initial begin
        #6_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

/* sim.f */
src/lgs_pkg.sv
src/lgs_row_cell.sv
src/lgs_row_eval.sv
src/lgs_ctrl.sv
src/life_generation_step.sv
verif/testbench.sv
